FILE: hw/rtl/rem_pkg.sv
// Shared types, command codes and constants for the regression metrics block.
`timescale 1ns / 1ps
package rem_pkg;

    // Field widths of the result word, and the width of the predictor count (K_W).
    localparam int MAE_W  = 25;
    localparam int MSE_W  = 42;
    localparam int RMSE_W = 25;
    localparam int R2_W   = 24;
    localparam int K_W    = 8;

    // Operations of the shared serial engine.
    localparam logic [3:0] OP_MAE  = 4'd0;
    localparam logic [3:0] OP_MSE  = 4'd1;
    localparam logic [3:0] OP_SQRT = 4'd2;
    localparam logic [3:0] OP_MULA = 4'd3;
    localparam logic [3:0] OP_MULB = 4'd4;
    localparam logic [3:0] OP_MULC = 4'd5;
    localparam logic [3:0] OP_DIVQ = 4'd6;
    localparam logic [3:0] OP_MULT = 4'd7;
    localparam logic [3:0] OP_DIVT = 4'd8;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_ZVAR   = 2'd2;
    localparam logic [1:0] ST_BADADJ = 2'd3;

    // Register addresses.
    localparam logic [2:0] ADDR_NUM_PRED = 3'd0;

    // Engine constants.
    localparam logic [63:0] CAP_MAE  = 64'h0000_0000_01FF_FFFF;
    localparam logic [63:0] CAP_MSE  = 64'h0000_03FF_FFFF_FFFF;
    localparam logic [63:0] CAP_Q    = 64'h0000_0001_0000_0000;
    localparam logic [63:0] SQRT_BIT = 64'h0001_0000_0000_0000;
    localparam logic [5:0]  SQRT_LAST = 6'd24;
    localparam logic [5:0]  STEP_LAST = 6'd63;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       acc;
        logic       start;
        logic [3:0] op;
        logic       load;
        logic [1:0] status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
        logic n_zero;
        logic d_zero;
        logic den_bad;
        logic out_free;
    } t_stat;

endpackage

FILE: hw/rtl/rem_in_if.sv
// Input channel carrying one sample pair word.
`timescale 1ns / 1ps
interface rem_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] actual;
    logic signed [15:0] predicted;
    logic               last;

    modport source (output valid, output actual, output predicted, output last, input ready);
    modport sink (input valid, input actual, input predicted, input last, output ready);
endinterface

FILE: hw/rtl/rem_out_if.sv
// Output channel carrying one metrics result word.
`timescale 1ns / 1ps
interface rem_out_if;
    logic               valid;
    logic               ready;
    logic        [24:0] mae;
    logic        [41:0] mse;
    logic        [24:0] rmse;
    logic signed [23:0] r_squared;
    logic signed [23:0] adj_r2;
    logic        [1:0]  status;

    modport source (output valid, output mae, output mse, output rmse, output r_squared,
                     output adj_r2, output status, input ready);
    modport sink (input valid, input mae, input mse, input rmse, input r_squared,
                  input adj_r2, input status, output ready);
endinterface

FILE: hw/rtl/rem_datapath.sv
// Accumulators, shared serial multiply/divide/root engine and result register.
`timescale 1ns / 1ps
module rem_datapath #(
    parameter int MAX_SAMPLES = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rem_pkg::t_cmd          i_cmd,
    output rem_pkg::t_stat         o_stat,
    input  logic signed [15:0]     i_actual,
    input  logic signed [15:0]     i_predicted,
    input  logic [rem_pkg::K_W-1:0] i_num_pred,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [24:0]            o_mae,
    output logic [41:0]            o_mse,
    output logic [24:0]            o_rmse,
    output logic signed [23:0]     o_r_squared,
    output logic signed [23:0]     o_adj_r2,
    output logic [1:0]             o_status
);
    import rem_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int XW   = (SB > 16) ? SB : 16;
    localparam int SAEW = ((SB + 1 + CW) > 64) ? 64 : (SB + 1 + CW);
    localparam int SSEW = ((2 * SB + 2 + CW) > 64) ? 64 : (2 * SB + 2 + CW);
    localparam int SAW  = ((SB + CW) > 64) ? 64 : (SB + CW);
    localparam int SAQW = ((2 * SB + CW) > 64) ? 64 : (2 * SB + CW);
    localparam int DW   = ((CW > K_W) ? CW : K_W) + 1;
    localparam logic [CW-1:0] MAXC = CW'(MAX_SAMPLES);

    localparam logic [1:0] M_MUL  = 2'd0;
    localparam logic [1:0] M_DIV  = 2'd1;
    localparam logic [1:0] M_SQRT = 2'd2;

    // Accumulators.
    logic [CW-1:0]          r_cnt;
    logic [SAEW-1:0]        r_sae;
    logic [SSEW-1:0]        r_sse;
    logic signed [SAW-1:0]  r_sa;
    logic [SAQW-1:0]        r_saq;

    // Sample decode: low SAMPLE_BITS bits of each field as two's complement.
    logic [XW-1:0]          w_xa, w_xp;
    logic signed [SB-1:0]   w_a, w_p;
    logic signed [SB:0]     w_e;
    logic [SB:0]            w_ae;
    logic signed [2*SB-1:0] w_asq;
    logic [2*SB+1:0]        w_aesq;

    assign w_xa   = XW'($unsigned(i_actual));
    assign w_xp   = XW'($unsigned(i_predicted));
    assign w_a    = w_xa[SB-1:0];
    assign w_p    = w_xp[SB-1:0];
    assign w_e    = {w_a[SB-1], w_a} - {w_p[SB-1], w_p};
    assign w_ae   = w_e[SB] ? $unsigned(-w_e) : $unsigned(w_e);
    assign w_asq  = w_a * w_a;
    assign w_aesq = w_ae * w_ae;

    // Accumulate while the count is below its limit; clear when a result loads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_cnt <= '0;
            r_sae <= '0;
            r_sse <= '0;
            r_sa  <= '0;
            r_saq <= '0;
        end else if (i_cmd.acc && (r_cnt < MAXC)) begin
            r_cnt <= r_cnt + CW'(1);
            r_sae <= r_sae + SAEW'(w_ae);
            r_sse <= r_sse + SSEW'(w_aesq);
            r_sa  <= r_sa + SAW'(w_a);
            r_saq <= r_saq + SAQW'($unsigned(w_asq));
        end
    end

    // Adjustment denominator n - k - 1.
    logic [DW-1:0] w_den;
    logic          w_den_bad;
    assign w_den     = DW'(r_cnt) - DW'(i_num_pred) - DW'(1);
    assign w_den_bad = DW'(r_cnt) <= (DW'(i_num_pred) + DW'(1));

    // Serial engine registers, shared between multiply, divide and root.
    logic [63:0] r_a, r_b, r_ph, r_pl, r_cap;
    logic [63:0] n_a, n_b, n_ph, n_pl, n_cap;
    logic [5:0]  r_step, n_step;
    logic [1:0]  r_mode, n_mode;
    logic [3:0]  r_op, n_op;
    logic        r_run, n_run, r_skip, n_skip, r_done, n_done;
    logic [63:0] r_d, n_d;
    logic [24:0] r_mae, n_mae, r_rmse, n_rmse;
    logic [41:0] r_mse, n_mse;
    logic [32:0] r_qv, n_qv, r_t, n_t;

    // Step helpers.
    logic [64:0] w_msum;
    logic        w_carry, w_sub;
    logic [63:0] w_rem2, w_qn, w_qc, w_ssum;

    assign w_msum  = {1'b0, r_ph} + (r_b[0] ? {1'b0, r_a} : 65'd0);
    assign w_carry = r_ph[63];
    assign w_rem2  = {r_ph[62:0], r_pl[63]};
    assign w_sub   = w_carry || (w_rem2 >= r_a);
    assign w_qn    = r_skip ? r_cap : {r_b[62:0], w_sub};
    assign w_qc    = (w_qn > r_cap) ? r_cap : w_qn;
    assign w_ssum  = r_pl + r_a;

    always_comb begin
        logic [63:0] v_hi, v_lo, v_d, v_cap;
        logic        v_div;
        n_a    = r_a;
        n_b    = r_b;
        n_ph   = r_ph;
        n_pl   = r_pl;
        n_cap  = r_cap;
        n_step = r_step;
        n_mode = r_mode;
        n_op   = r_op;
        n_run  = r_run;
        n_skip = r_skip;
        n_done = 1'b0;
        n_d    = r_d;
        n_mae  = r_mae;
        n_mse  = r_mse;
        n_rmse = r_rmse;
        n_qv   = r_qv;
        n_t    = r_t;
        v_hi   = '0;
        v_lo   = '0;
        v_d    = '0;
        v_cap  = '0;
        v_div  = 1'b0;

        if (i_cmd.start) begin
            n_op   = i_cmd.op;
            n_run  = 1'b1;
            n_step = '0;
            n_ph   = '0;
            n_pl   = '0;
            n_b    = '0;
            n_mode = M_MUL;
            case (i_cmd.op)
                OP_MAE: begin
                    v_div = 1'b1;
                    v_hi  = 64'(r_sae) >> 56;
                    v_lo  = 64'(r_sae) << 8;
                    v_d   = 64'(r_cnt);
                    v_cap = CAP_MAE;
                end
                OP_MSE: begin
                    v_div = 1'b1;
                    v_hi  = 64'(r_sse) >> 56;
                    v_lo  = 64'(r_sse) << 8;
                    v_d   = 64'(r_cnt);
                    v_cap = CAP_MSE;
                end
                OP_SQRT: begin
                    n_mode = M_SQRT;
                    n_ph   = {14'd0, r_mse, 8'd0};
                    n_a    = SQRT_BIT;
                end
                OP_MULA: begin
                    n_a = 64'(r_cnt);
                    n_b = 64'(r_saq);
                end
                OP_MULB: begin
                    n_a = 64'(r_sa);
                    n_b = 64'(r_sa);
                end
                OP_MULC: begin
                    n_a = 64'(r_cnt);
                    n_b = 64'(r_sse);
                end
                OP_DIVQ: begin
                    v_div = 1'b1;
                    v_hi  = r_ph;
                    v_lo  = r_pl;
                    v_d   = r_d;
                    v_cap = CAP_Q;
                end
                OP_MULT: begin
                    n_a = 64'(r_qv);
                    n_b = 64'(r_cnt) - 64'd1;
                end
                OP_DIVT: begin
                    v_div = 1'b1;
                    v_hi  = '0;
                    v_lo  = r_pl;
                    v_d   = 64'(w_den);
                    v_cap = CAP_Q;
                end
                default: begin
                    n_run = 1'b0;
                end
            endcase
            if (v_div) begin
                n_mode = M_DIV;
                n_ph   = v_hi;
                n_pl   = v_lo;
                n_a    = v_d;
                n_cap  = v_cap;
                n_skip = (v_d == 64'd0) || (v_hi >= v_d);
            end
        end else if (r_run) begin
            n_step = r_step + 6'd1;
            case (r_mode)
                M_MUL: begin
                    n_ph = w_msum[64:1];
                    n_pl = {w_msum[0], r_pl[63:1]};
                    n_b  = r_b >> 1;
                    if (r_step == STEP_LAST) begin
                        n_run  = 1'b0;
                        n_done = 1'b1;
                        case (r_op)
                            OP_MULA: n_d = n_pl;
                            OP_MULB: n_d = r_d - n_pl;
                            OP_MULC: begin
                                n_ph = {n_ph[47:0], n_pl[63:48]};
                                n_pl = {n_pl[47:0], 16'd0};
                            end
                            default: ;
                        endcase
                    end
                end
                M_DIV: begin
                    n_pl = {r_pl[62:0], 1'b0};
                    n_ph = w_sub ? (w_rem2 - r_a) : w_rem2;
                    n_b  = {r_b[62:0], w_sub};
                    if (r_skip || (r_step == STEP_LAST)) begin
                        n_run  = 1'b0;
                        n_done = 1'b1;
                        n_skip = 1'b0;
                        case (r_op)
                            OP_MAE:  n_mae = w_qc[24:0];
                            OP_MSE:  n_mse = w_qc[41:0];
                            OP_DIVQ: n_qv  = w_qc[32:0];
                            OP_DIVT: n_t   = w_qc[32:0];
                            default: ;
                        endcase
                    end
                end
                default: begin
                    // One result bit per step of the digit-by-digit root.
                    if (r_ph >= w_ssum) begin
                        n_ph = r_ph - w_ssum;
                        n_pl = (r_pl >> 1) + r_a;
                    end else begin
                        n_pl = r_pl >> 1;
                    end
                    n_a = r_a >> 2;
                    if (r_step == SQRT_LAST) begin
                        n_run  = 1'b0;
                        n_done = 1'b1;
                        n_rmse = n_pl[24:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_skip <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_skip <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_ph   <= n_ph;
        r_pl   <= n_pl;
        r_cap  <= n_cap;
        r_step <= n_step;
        r_mode <= n_mode;
        r_op   <= n_op;
        r_d    <= n_d;
        r_mae  <= n_mae;
        r_mse  <= n_mse;
        r_rmse <= n_rmse;
        r_qv   <= n_qv;
        r_t    <= n_t;
    end

    // Q16 one minus the ratio, saturated to the signed 24-bit range.
    function automatic logic signed [23:0] sat_q16(input logic [32:0] q);
        logic signed [34:0] v;
        v = 35'sd65536 - $signed({2'b00, q});
        if (v > 35'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -35'sd8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

    // Result register; holds the word until the sink takes it.
    logic r_ovalid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_status <= i_cmd.status;
            if (i_cmd.status == ST_EMPTY) begin
                o_mae  <= '0;
                o_mse  <= '0;
                o_rmse <= '0;
            end else begin
                o_mae  <= r_mae;
                o_mse  <= r_mse;
                o_rmse <= r_rmse;
            end
            if ((i_cmd.status == ST_OK) || (i_cmd.status == ST_BADADJ)) begin
                o_r_squared <= sat_q16(r_qv);
            end else begin
                o_r_squared <= '0;
            end
            if (i_cmd.status == ST_OK) begin
                o_adj_r2 <= sat_q16(r_t);
            end else begin
                o_adj_r2 <= '0;
            end
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_stat.done     = r_done;
    assign o_stat.n_zero   = (r_cnt == '0);
    assign o_stat.d_zero   = (r_d == 64'd0);
    assign o_stat.den_bad  = w_den_bad;
    assign o_stat.out_free = !r_ovalid || i_out_ready;

endmodule

FILE: hw/rtl/rem_ctrl.sv
// Controller that accepts pairs and sequences the end-of-batch computation.
`timescale 1ns / 1ps
module rem_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_last,
    output logic           o_ready,
    output rem_pkg::t_cmd  o_cmd,
    input  rem_pkg::t_stat i_stat
);
    import rem_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_MAE   = 4'd2;
    localparam logic [3:0] S_MSE   = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_MULA  = 4'd5;
    localparam logic [3:0] S_MULB  = 4'd6;
    localparam logic [3:0] S_CHKD  = 4'd7;
    localparam logic [3:0] S_MULC  = 4'd8;
    localparam logic [3:0] S_DIVQ  = 4'd9;
    localparam logic [3:0] S_MULT  = 4'd10;
    localparam logic [3:0] S_DIVT  = 4'd11;
    localparam logic [3:0] S_LOAD  = 4'd12;

    logic [3:0] r_state, n_state;
    logic       r_wait, n_wait;
    logic [1:0] r_st, n_st;
    logic       w_acc;

    assign o_ready = (r_state == S_IDLE);
    assign w_acc   = o_ready && i_valid;

    // Each engine state issues its operation once and moves on when it completes.
    always_comb begin
        n_state      = r_state;
        n_wait       = r_wait;
        n_st         = r_st;
        o_cmd.acc    = w_acc;
        o_cmd.start  = 1'b0;
        o_cmd.op     = OP_MAE;
        o_cmd.load   = 1'b0;
        o_cmd.status = r_st;
        case (r_state)
            S_IDLE: begin
                if (w_acc && i_last) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_stat.n_zero) begin
                    n_st    = ST_EMPTY;
                    n_state = S_LOAD;
                end else begin
                    n_st    = ST_OK;
                    n_state = S_MAE;
                end
            end
            S_CHKD: begin
                if (i_stat.d_zero) begin
                    n_st    = ST_ZVAR;
                    n_state = S_LOAD;
                end else begin
                    n_state = S_MULC;
                end
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                case (r_state)
                    S_MAE:   o_cmd.op = OP_MAE;
                    S_MSE:   o_cmd.op = OP_MSE;
                    S_SQRT:  o_cmd.op = OP_SQRT;
                    S_MULA:  o_cmd.op = OP_MULA;
                    S_MULB:  o_cmd.op = OP_MULB;
                    S_MULC:  o_cmd.op = OP_MULC;
                    S_DIVQ:  o_cmd.op = OP_DIVQ;
                    S_MULT:  o_cmd.op = OP_MULT;
                    default: o_cmd.op = OP_DIVT;
                endcase
                o_cmd.start = !r_wait;
                n_wait      = 1'b1;
                if (r_wait && i_stat.done) begin
                    n_wait = 1'b0;
                    case (r_state)
                        S_MULB: n_state = S_CHKD;
                        S_DIVQ: begin
                            if (i_stat.den_bad) begin
                                n_st    = ST_BADADJ;
                                n_state = S_LOAD;
                            end else begin
                                n_state = S_MULT;
                            end
                        end
                        S_DIVT:  n_state = S_LOAD;
                        S_MAE, S_MSE, S_SQRT, S_MULA, S_MULC, S_MULT:
                            n_state = r_state + 4'd1;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
            r_st    <= ST_OK;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
            r_st    <= n_st;
        end
    end

endmodule

FILE: hw/rtl/regression_error_metrics_core.sv
// Pairs are taken one per cycle while the input is ready; after the last pair of a batch
// the result is computed by the shared serial engine (eight multiply or divide passes
// of up to 64 steps each and a 25-step square root).
// Input is held off during that computation; a finished result waits in its own
// register while the next batch streams in.
// Reset (synchronous, active low) clears the accumulators and sets num_predictors to 1.
`timescale 1ns / 1ps
module regression_error_metrics_core #(
    parameter int MAX_SAMPLES = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rem_in_if.sink      i_in,
    rem_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rem_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic [K_W-1:0] r_num_pred;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_pred <= K_W'(1);
        end else if (psel && penable && pwrite && (paddr[2] == ADDR_NUM_PRED[2])) begin
            r_num_pred <= pwdata[K_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_NUM_PRED[2]) ? 32'(r_num_pred) : 32'd0;

    rem_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_last  (i_in.last),
        .o_ready (i_in.ready),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    rem_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_actual    (i_in.actual),
        .i_predicted (i_in.predicted),
        .i_num_pred  (r_num_pred),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_mae       (o_out.mae),
        .o_mse       (o_out.mse),
        .o_rmse      (o_out.rmse),
        .o_r_squared (o_out.r_squared),
        .o_adj_r2    (o_out.adj_r2),
        .o_status    (o_out.status)
    );

endmodule

FILE: hw/rtl/rem_checker.sv
// Port-level checks on the result channel of the metrics core.
`timescale 1ns / 1ps
module rem_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input logic [24:0]        i_mae,
    input logic [41:0]        i_mse,
    input logic signed [23:0] i_r2,
    input logic signed [23:0] i_adj,
    input logic [1:0]         i_status
);
    import rem_pkg::*;

    // A stalled result word holds its status.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_status)))
        else $error("result word changed while stalled");

    // An empty batch reports zero MAE and MSE.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_status == ST_EMPTY)) |-> ((i_mae == '0) && (i_mse == '0)))
        else $error("empty batch carries nonzero errors");

    // Zero variance zeroes both goodness-of-fit values.
    a_zvar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_status == ST_ZVAR)) |-> ((i_r2 == '0) && (i_adj == '0)))
        else $error("zero variance with nonzero R-squared");

    // A bad adjustment denominator zeroes the adjusted value.
    a_badadj: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_status == ST_BADADJ)) |-> (i_adj == '0))
        else $error("bad adjustment with nonzero adjusted R-squared");

    // Reset leaves no result pending.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

endmodule

bind regression_error_metrics_core rem_checker u_rem_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_out.valid),
    .i_ready  (o_out.ready),
    .i_mae    (o_out.mae),
    .i_mse    (o_out.mse),
    .i_r2     (o_out.r_squared),
    .i_adj    (o_out.adj_r2),
    .i_status (o_out.status)
);
